>>> rtl/hole_table_heap_allocator_assert.svh
// assertion helpers for the heap allocator
`ifndef HOLE_TABLE_HEAP_ALLOCATOR_ASSERT_SVH
`define HOLE_TABLE_HEAP_ALLOCATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define HTHA_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("heap allocator check failed");

// next-cycle implication
`define HTHA_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("heap allocator check failed");

`else

`define HTHA_ASSERT_IMP(label, ante, cons)
`define HTHA_ASSERT_NXT(label, ante, cons)

`endif

`endif

>>> rtl/htha_pkg.sv
package htha_pkg;

   // default sizing
   localparam int DEF_INDEX_DEPTH = 64;
   localparam int DEF_PAGE_BYTES  = 4096;

   // block overhead: 12-byte header plus 8-byte footer
   localparam int unsigned OVERHEAD     = 20;
   localparam int unsigned HEADER_BYTES = 12;

   // register reset values
   localparam logic [31:0] RST_BODY_START  = 32'd0;
   localparam logic [31:0] RST_INITIAL_END = 32'd1048576;
   localparam logic [31:0] RST_MAX_END     = 32'd4294963200;

   // register indexes
   localparam int REG_INDEX_W = 2;
   localparam logic [REG_INDEX_W-1:0] REG_BODY_START  = 2'd0;
   localparam logic [REG_INDEX_W-1:0] REG_INITIAL_END = 2'd1;
   localparam logic [REG_INDEX_W-1:0] REG_MAX_END     = 2'd2;

   // result status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_GROWN   = 2'd1;
   localparam logic [1:0] ST_NO_ROOM = 2'd2;
   localparam logic [1:0] ST_FULL    = 2'd3;

   // datapath operations
   typedef enum logic [3:0] {
      OP_NONE,
      OP_INIT,
      OP_ACCEPT,
      OP_SCAN,
      OP_GROW_LEN,
      OP_GROW_CHK,
      OP_SPLIT,
      OP_CALC,
      OP_CHECK,
      OP_DEL_START,
      OP_DEL,
      OP_INS_START,
      OP_INS,
      OP_FINISH
   } op_type;

   typedef struct packed {
      op_type op;
      logic   sel_right;
   } cmd_type;

   typedef struct packed {
      logic init_pending;
      logic hit;
      logic loop_end;
      logic grow_fail;
      logic split_full;
      logic need_left;
      logic need_right;
      logic grown;
      logic ins_done;
      logic rsp_busy;
   } status_type;

endpackage

>>> rtl/htha_ram.sv
module htha_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_ff;

   // one write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   assign rd_data = rd_ff;

endmodule

>>> rtl/htha_datapath.sv
module htha_datapath import htha_pkg::*; #(
   parameter int INDEX_DEPTH = DEF_INDEX_DEPTH,
   parameter int PAGE_BYTES  = DEF_PAGE_BYTES
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output status_type             stat,
   input  logic [23:0]            req_tdata,
   input  logic [0:0]             req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [63:0]            rsp_tdata,
   output logic [1:0]             rsp_tuser,
   input  logic                   csr_we,
   input  logic [REG_INDEX_W-1:0] csr_index,
   input  logic [31:0]            csr_wdata
);

   localparam int AW = $clog2(INDEX_DEPTH);
   localparam int CW = $clog2(INDEX_DEPTH + 1);
   localparam int PW = $clog2(PAGE_BYTES);
   localparam int OW = PW + 1;
   localparam logic [CW-1:0] DEPTH_C   = CW'(INDEX_DEPTH);
   localparam logic [CW:0]   DEPTH_X   = (CW+1)'(INDEX_DEPTH);
   localparam logic [OW-1:0] PAGE_W    = OW'(PAGE_BYTES);
   localparam logic [33:0]   PAGE_M1   = 34'(PAGE_BYTES - 1);
   localparam logic [31:0]   OVH_W     = 32'(OVERHEAD);

   // offset that puts header start + 12 on a page boundary
   function automatic logic [OW-1:0] align_off(input logic [31:0] a);
      logic [PW-1:0] r;
      logic [OW-1:0] o;
      r = a[PW-1:0] + PW'(HEADER_BYTES);
      o = '0;
      if (r != '0) begin
         o = PAGE_W - OW'(r);
         if (o <= OW'(OVERHEAD)) begin
            o = o + PAGE_W;
         end
      end
      return o;
   endfunction

   logic [31:0]   body_ff, body_in, init_end_ff, init_end_in, max_end_ff, max_end_in;
   logic [31:0]   heap_end_ff, heap_end_in;
   logic [CW-1:0] count_ff, count_in, ptr_ff, ptr_in;
   logic          pending_ff, pending_in, rsp_valid_ff, rsp_valid_in;
   logic [31:0]   rsp_addr_ff, rsp_addr_in, rsp_grant_ff, rsp_grant_in;
   logic [1:0]    rsp_code_ff, rsp_code_in, code_ff, code_in;
   logic [24:0]   need_ff, need_in;
   logic          pa_ff, pa_in, grown_ff, grown_in, rdv_ff, rdv_in;
   logic [AW-1:0] rd_idx_ff, rd_idx_in, hit_idx_ff, hit_idx_in;
   logic [31:0]   hole_a_ff, hole_a_in, hole_s_ff, hole_s_in, te_new_ff, te_new_in;
   logic [33:0]   len_ff, len_in;
   logic [OW-1:0] off_ff, off_in;
   logic [31:0]   base_ff, base_in, avail_ff, avail_in, rem_ff, rem_in;
   logic [31:0]   grant_ff, grant_in, ins_a_ff, ins_a_in, ins_s_ff, ins_s_in;

   logic          ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [63:0]   ram_wdata, rd_data;
   logic [31:0]   rd_a, rd_s, old_len;
   logic [OW-1:0] grow_off;
   logic [33:0]   len_raw;
   logic [34:0]   new_end;
   logic [CW:0]   count_eff;
   logic          fit, hit, loop_end, room_fail, full_grow, need_left, need_right;
   logic          split_full, ins_stop, ins_done, failed;

   htha_ram #(
      .WIDTH(64),
      .DEPTH(INDEX_DEPTH)
   ) u_table (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(rd_data)
   );

   // entry fields and per-entry checks
   assign rd_a = rd_data[63:32];
   assign rd_s = rd_data[31:0];
   assign fit  = rd_s >= (32'(need_ff) + 32'(pa_ff ? align_off(rd_a) : '0));
   assign hit  = rdv_ff && fit;
   assign loop_end = !rdv_ff && (ptr_ff >= count_ff);

   // growth arithmetic
   assign old_len   = heap_end_ff - body_ff;
   assign grow_off  = pa_ff ? align_off(heap_end_ff) : '0;
   assign len_raw   = 34'(old_len) + 34'(need_ff) + 34'(grow_off);
   assign new_end   = 35'(body_ff) + 35'(len_ff);
   assign room_fail = new_end > 35'(max_end_ff);
   assign full_grow = count_ff >= DEPTH_C;

   // split decisions
   assign need_left  = off_ff != '0;
   assign need_right = rem_ff > OVH_W;
   assign count_eff  = (CW+1)'(count_ff) + (CW+1)'(need_left) - (CW+1)'(!grown_ff);
   assign split_full = need_right && (count_eff >= DEPTH_X);

   // ordered insert walks down from the top entry
   assign ins_stop = rdv_ff && (rd_s < ins_s_ff);
   assign ins_done = ins_stop || (!rdv_ff && ptr_ff == '0);
   assign failed   = (code_ff == ST_NO_ROOM) || (code_ff == ST_FULL);

   assign stat.init_pending = pending_ff;
   assign stat.hit          = hit;
   assign stat.loop_end     = loop_end;
   assign stat.grow_fail    = room_fail || full_grow;
   assign stat.split_full   = split_full;
   assign stat.need_left    = need_left;
   assign stat.need_right   = need_right;
   assign stat.grown        = grown_ff;
   assign stat.ins_done     = ins_done;
   assign stat.rsp_busy     = rsp_valid_ff && !rsp_tready;

   // next-state logic per operation
   always_comb begin
      body_in      = body_ff;
      init_end_in  = init_end_ff;
      max_end_in   = max_end_ff;
      heap_end_in  = heap_end_ff;
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      pending_in   = pending_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_addr_in  = rsp_addr_ff;
      rsp_grant_in = rsp_grant_ff;
      rsp_code_in  = rsp_code_ff;
      code_in      = code_ff;
      need_in      = need_ff;
      pa_in        = pa_ff;
      grown_in     = grown_ff;
      rdv_in       = 1'b0;
      rd_idx_in    = rd_idx_ff;
      hit_idx_in   = hit_idx_ff;
      hole_a_in    = hole_a_ff;
      hole_s_in    = hole_s_ff;
      te_new_in    = te_new_ff;
      len_in       = len_ff;
      off_in       = off_ff;
      base_in      = base_ff;
      avail_in     = avail_ff;
      rem_in       = rem_ff;
      grant_in     = grant_ff;
      ins_a_in     = ins_a_ff;
      ins_s_in     = ins_s_ff;
      ram_we       = 1'b0;
      ram_waddr    = '0;
      ram_wdata    = '0;
      ram_raddr    = ptr_ff[AW-1:0];

      case (cmd.op)
         OP_INIT: begin
            ram_we     = 1'b1;
            ram_wdata  = {body_ff, init_end_ff - body_ff};
            pending_in = 1'b0;
         end
         OP_ACCEPT: begin
            need_in  = 25'(req_tdata) + 25'(OVERHEAD);
            pa_in    = req_tuser[0];
            code_in  = ST_OK;
            grown_in = 1'b0;
            ptr_in   = '0;
         end
         OP_SCAN: begin
            if (ptr_ff < count_ff) begin
               rdv_in    = 1'b1;
               rd_idx_in = ptr_ff[AW-1:0];
               ptr_in    = ptr_ff + CW'(1);
            end
            if (hit) begin
               hole_a_in  = rd_a;
               hole_s_in  = rd_s;
               hit_idx_in = rd_idx_ff;
            end
         end
         OP_GROW_LEN: begin
            len_in = (len_raw + PAGE_M1) & ~PAGE_M1;
         end
         OP_GROW_CHK: begin
            if (room_fail) begin
               code_in = ST_NO_ROOM;
            end else if (full_grow) begin
               code_in = ST_FULL;
            end else begin
               hole_a_in = heap_end_ff;
               hole_s_in = len_ff[31:0] - old_len;
               te_new_in = new_end[31:0];
               grown_in  = 1'b1;
               code_in   = ST_GROWN;
            end
         end
         OP_SPLIT: begin
            off_in = pa_ff ? align_off(hole_a_ff) : '0;
         end
         OP_CALC: begin
            base_in  = hole_a_ff + 32'(off_ff);
            avail_in = hole_s_ff - 32'(off_ff);
            rem_in   = hole_s_ff - 32'(off_ff) - 32'(need_ff);
         end
         OP_CHECK: begin
            grant_in = need_right ? 32'(need_ff) : avail_ff;
            if (split_full) begin
               code_in = ST_FULL;
            end
         end
         OP_DEL_START: begin
            ptr_in = CW'(hit_idx_ff) + CW'(1);
         end
         OP_DEL: begin
            if (ptr_ff < count_ff) begin
               rdv_in    = 1'b1;
               rd_idx_in = ptr_ff[AW-1:0];
               ptr_in    = ptr_ff + CW'(1);
            end
            // move the entry read last cycle one place down
            if (rdv_ff) begin
               ram_we    = 1'b1;
               ram_waddr = rd_idx_ff - AW'(1);
               ram_wdata = rd_data;
            end
            if (loop_end) begin
               count_in = count_ff - CW'(1);
            end
         end
         OP_INS_START: begin
            ptr_in   = count_ff;
            ins_a_in = cmd.sel_right ? base_ff + 32'(need_ff) : hole_a_ff;
            ins_s_in = cmd.sel_right ? rem_ff : 32'(off_ff);
         end
         OP_INS: begin
            ram_raddr = AW'(ptr_ff - CW'(1));
            if (ptr_ff != '0) begin
               rdv_in    = 1'b1;
               rd_idx_in = AW'(ptr_ff - CW'(1));
               ptr_in    = ptr_ff - CW'(1);
            end
            // shift larger-or-equal entries up, drop the new hole in the gap
            if (rdv_ff) begin
               ram_we    = 1'b1;
               ram_waddr = rd_idx_ff + AW'(1);
               ram_wdata = ins_stop ? {ins_a_ff, ins_s_ff} : rd_data;
            end else if (ptr_ff == '0) begin
               ram_we    = 1'b1;
               ram_wdata = {ins_a_ff, ins_s_ff};
            end
            if (ins_done) begin
               count_in = count_ff + CW'(1);
            end
         end
         OP_FINISH: begin
            rsp_valid_in = 1'b1;
            rsp_code_in  = code_ff;
            if (failed) begin
               rsp_addr_in  = '0;
               rsp_grant_in = '0;
            end else begin
               rsp_addr_in  = base_ff + 32'(HEADER_BYTES);
               rsp_grant_in = grant_ff;
               if (grown_ff) begin
                  heap_end_in = te_new_ff;
               end
            end
         end
         default: begin
         end
      endcase

      // register writes: the user must write only while idle; the block does not enforce it
      if (csr_we) begin
         unique case (csr_index)
            REG_BODY_START: begin
               body_in     = csr_wdata;
               count_in    = CW'(1);
               heap_end_in = init_end_ff;
               pending_in  = 1'b1;
            end
            REG_INITIAL_END: begin
               init_end_in = csr_wdata;
               count_in    = CW'(1);
               heap_end_in = csr_wdata;
               pending_in  = 1'b1;
            end
            REG_MAX_END: begin
               max_end_in = csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // control and register state
   always_ff @(posedge clock) begin
      if (reset) begin
         body_ff      <= RST_BODY_START;
         init_end_ff  <= RST_INITIAL_END;
         max_end_ff   <= RST_MAX_END;
         heap_end_ff  <= RST_INITIAL_END;
         count_ff     <= CW'(1);
         pending_ff   <= 1'b1;
         rsp_valid_ff <= 1'b0;
         rdv_ff       <= 1'b0;
      end else begin
         body_ff      <= body_in;
         init_end_ff  <= init_end_in;
         max_end_ff   <= max_end_in;
         heap_end_ff  <= heap_end_in;
         count_ff     <= count_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
         rdv_ff       <= rdv_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      ptr_ff       <= ptr_in;
      rsp_addr_ff  <= rsp_addr_in;
      rsp_grant_ff <= rsp_grant_in;
      rsp_code_ff  <= rsp_code_in;
      code_ff      <= code_in;
      need_ff      <= need_in;
      pa_ff        <= pa_in;
      grown_ff     <= grown_in;
      rd_idx_ff    <= rd_idx_in;
      hit_idx_ff   <= hit_idx_in;
      hole_a_ff    <= hole_a_in;
      hole_s_ff    <= hole_s_in;
      te_new_ff    <= te_new_in;
      len_ff       <= len_in;
      off_ff       <= off_in;
      base_ff      <= base_in;
      avail_ff     <= avail_in;
      rem_ff       <= rem_in;
      grant_ff     <= grant_in;
      ins_a_ff     <= ins_a_in;
      ins_s_ff     <= ins_s_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_grant_ff, rsp_addr_ff};
   assign rsp_tuser  = rsp_code_ff;

endmodule

>>> rtl/htha_ctrl.sv
module htha_ctrl import htha_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type stat,
   output cmd_type    cmd
);

   typedef enum logic [12:0] {
      S_IDLE      = 13'b0000000000001,
      S_SCAN      = 13'b0000000000010,
      S_GROW_LEN  = 13'b0000000000100,
      S_GROW_CHK  = 13'b0000000001000,
      S_SPLIT     = 13'b0000000010000,
      S_CALC      = 13'b0000000100000,
      S_CHECK     = 13'b0000001000000,
      S_DEL_START = 13'b0000010000000,
      S_DEL       = 13'b0000100000000,
      S_INS_START = 13'b0001000000000,
      S_INS       = 13'b0010000000000,
      S_FINISH    = 13'b0100000000000,
      S_SPARE     = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;
   logic      right_ff, right_in;

   // sequencing of one request
   always_comb begin
      state_in      = state_ff;
      right_in      = right_ff;
      req_tready    = 1'b0;
      cmd.op        = OP_NONE;
      cmd.sel_right = right_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (stat.init_pending) begin
               cmd.op = OP_INIT;
            end else begin
               req_tready = 1'b1;
               if (req_tvalid) begin
                  cmd.op   = OP_ACCEPT;
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            cmd.op = OP_SCAN;
            if (stat.hit) begin
               state_in = S_SPLIT;
            end else if (stat.loop_end) begin
               state_in = S_GROW_LEN;
            end
         end
         S_GROW_LEN: begin
            cmd.op   = OP_GROW_LEN;
            state_in = S_GROW_CHK;
         end
         S_GROW_CHK: begin
            cmd.op   = OP_GROW_CHK;
            state_in = stat.grow_fail ? S_FINISH : S_SPLIT;
         end
         S_SPLIT: begin
            cmd.op   = OP_SPLIT;
            state_in = S_CALC;
         end
         S_CALC: begin
            cmd.op   = OP_CALC;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            cmd.op = OP_CHECK;
            if (stat.split_full) begin
               state_in = S_FINISH;
            end else if (!stat.grown) begin
               state_in = S_DEL_START;
            end else if (stat.need_left) begin
               right_in = 1'b0;
               state_in = S_INS_START;
            end else if (stat.need_right) begin
               right_in = 1'b1;
               state_in = S_INS_START;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_DEL_START: begin
            cmd.op   = OP_DEL_START;
            state_in = S_DEL;
         end
         S_DEL: begin
            cmd.op = OP_DEL;
            if (stat.loop_end) begin
               if (stat.need_left) begin
                  right_in = 1'b0;
                  state_in = S_INS_START;
               end else if (stat.need_right) begin
                  right_in = 1'b1;
                  state_in = S_INS_START;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_INS_START: begin
            cmd.op   = OP_INS_START;
            state_in = S_INS;
         end
         S_INS: begin
            cmd.op = OP_INS;
            if (stat.ins_done) begin
               if (!right_ff && stat.need_right) begin
                  right_in = 1'b1;
                  state_in = S_INS_START;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_FINISH: begin
            if (!stat.rsp_busy) begin
               cmd.op   = OP_FINISH;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         right_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         right_ff <= right_in;
      end
   end

endmodule

>>> rtl/hole_table_heap_allocator.sv
// Best-fit heap allocator over a table of free holes kept in ascending size.
// Request channel req_*: request size in tdata, page-align flag in tuser.
// Result channel rsp_*: block address and granted size in tdata, status in
// tuser (ok, ok after growing, beyond max_end, hole table full).
// Register port csr_*: body_start, initial_end, max_end; writing either of
// the first two reloads the table with one hole and resets the heap end.
// One request is handled at a time: a scan of the holes, then a walk of the
// table for each removal or ordered insertion (up to three walks), each
// moving entries one place through the hole table memory, which does one
// read and one write per cycle.
// After reset, or a reload write, the initial hole is written before the
// request channel shows ready.
// A finished result sits in the output register; if the receiver stalls,
// the next request is taken and worked, then waits to deliver its result.
// PAGE_BYTES must be a power of two.
module hole_table_heap_allocator import htha_pkg::*; #(
   parameter int INDEX_DEPTH = DEF_INDEX_DEPTH,
   parameter int PAGE_BYTES  = DEF_PAGE_BYTES
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [23:0]            req_tdata,   // request_size
   input  logic [0:0]             req_tuser,   // align_to_page
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [63:0]            rsp_tdata,   // block_address, granted_size
   output logic [1:0]             rsp_tuser,   // status
   input  logic                   csr_we,
   input  logic [REG_INDEX_W-1:0] csr_index,
   input  logic [31:0]            csr_wdata
);

`include "hole_table_heap_allocator_assert.svh"

   cmd_type    ctl_cmd;
   status_type dp_stat;

   htha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .stat      (dp_stat),
      .cmd       (ctl_cmd)
   );

   htha_datapath #(
      .INDEX_DEPTH(INDEX_DEPTH),
      .PAGE_BYTES (PAGE_BYTES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (ctl_cmd),
      .stat      (dp_stat),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // one item in flight: no second accept right after one
   `HTHA_ASSERT_NXT(a_one_in_flight, req_tvalid && req_tready, !req_tready)
   // failed results carry zero address and size
   `HTHA_ASSERT_IMP(a_fail_zero, rsp_tvalid && (rsp_tuser >= ST_NO_ROOM), rsp_tdata == '0)
   // request capture only on a handshake
   `HTHA_ASSERT_IMP(a_capture_hs, ctl_cmd.op == OP_ACCEPT, req_tvalid && req_tready)

endmodule

>>> sim/hole_table_heap_allocator_test.sv
`timescale 1ns / 100ps

module hole_table_heap_allocator_test;
   import htha_pkg::*;

   localparam int DEPTH        = DEF_INDEX_DEPTH;
   localparam int PAGE         = DEF_PAGE_BYTES;
   localparam int SETTLE       = 4 * DEPTH + 48;
   localparam int STALL_LIMIT  = 6000;
   localparam int RANDOM_ITEMS = 1500;
   localparam logic [REG_INDEX_W-1:0] REG_UNUSED = 2'd3;

   typedef struct packed {
      logic [31:0] address;
      logic [31:0] granted;
      logic [1:0]  status;
   } alloc_result;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [23:0]            req_tdata;
   logic [0:0]             req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [63:0]            rsp_tdata;   // block_address, granted_size
   logic [1:0]             rsp_tuser;   // status
   logic                   csr_we;
   logic [REG_INDEX_W-1:0] csr_index;
   logic [31:0]            csr_wdata;

   hole_table_heap_allocator u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // allocator state mirrored by the predictor
   logic [31:0] body_start_q, initial_end_q, max_end_q, heap_top;
   logic [31:0] hole_addr [DEPTH];
   logic [31:0] hole_len  [DEPTH];
   int          hole_cnt;

   // scratch copy of the table for one request
   logic [31:0] work_addr [DEPTH];
   logic [31:0] work_len  [DEPTH];
   int          work_cnt;

   alloc_result pending_allocs[$];
   int          error_count = 0;
   int          burst_left;
   int          quiet_cycles = 0;
   int          cycle_count = 0;
   int          stall_mode = 0;

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic void reload_holes();
      hole_addr[0] = body_start_q;
      hole_len[0]  = initial_end_q - body_start_q;
      hole_cnt     = 1;
      heap_top     = initial_end_q;
   endfunction

   // bytes to skip so that header start + 12 lands on a page
   function automatic logic [31:0] align_pad(logic [31:0] a);
      logic [31:0] sum;
      logic [31:0] r;
      logic [31:0] o;
      sum = a + HEADER_BYTES;
      r   = sum % PAGE;
      if (r == 0) return 0;
      o = PAGE - r;
      if (o <= OVERHEAD) o = o + PAGE;
      return o;
   endfunction

   function automatic int find_fit(logic [31:0] need, bit pa);
      logic [63:0] want;
      for (int i = 0; i < work_cnt; i++) begin
         want = 64'(need) + (pa ? 64'(align_pad(work_addr[i])) : 64'd0);
         if (64'(work_len[i]) >= want) return i;
      end
      return work_cnt;
   endfunction

   // insert before holes of equal size
   function automatic void insert_hole(logic [31:0] a, logic [31:0] s);
      int p;
      p = 0;
      while (p < work_cnt && work_len[p] < s) p++;
      for (int j = work_cnt; j > p; j--) begin
         work_addr[j] = work_addr[j-1];
         work_len[j]  = work_len[j-1];
      end
      work_addr[p] = a;
      work_len[p]  = s;
      work_cnt++;
   endfunction

   function automatic void remove_hole(int i);
      for (int j = i; j < work_cnt - 1; j++) begin
         work_addr[j] = work_addr[j+1];
         work_len[j]  = work_len[j+1];
      end
      work_cnt--;
   endfunction

   function automatic alloc_result allocate(logic [23:0] size, bit pa);
      alloc_result res;
      logic [31:0] need, top, old_len, a, s, off, base, avail, rem, grant;
      logic [63:0] len, new_end;
      logic [1:0]  st;
      int          i;
      res  = '0;
      need = 32'(size) + OVERHEAD;
      top  = heap_top;
      st   = ST_OK;
      for (int j = 0; j < DEPTH; j++) begin
         work_addr[j] = hole_addr[j];
         work_len[j]  = hole_len[j];
      end
      work_cnt = hole_cnt;
      i = find_fit(need, pa);
      // no hole fits: grow the heap by whole pages
      if (i == work_cnt) begin
         old_len = top - body_start_q;
         len = 64'(old_len) + 64'(need) + (pa ? 64'(align_pad(top)) : 64'd0);
         len = ((len + PAGE - 1) / PAGE) * PAGE;
         new_end = 64'(body_start_q) + len;
         if (new_end > 64'(max_end_q)) begin
            res.status = ST_NO_ROOM;
            return res;
         end
         if (work_cnt >= DEPTH) begin
            res.status = ST_FULL;
            return res;
         end
         insert_hole(top, 32'(len - 64'(old_len)));
         top = new_end[31:0];
         i = find_fit(need, pa);
         if (i == work_cnt) begin
            res.status = ST_NO_ROOM;
            return res;
         end
         st = ST_GROWN;
      end
      // split into left pad hole, block and right remainder
      a   = work_addr[i];
      s   = work_len[i];
      off = pa ? align_pad(a) : 32'd0;
      remove_hole(i);
      if (off != 0) insert_hole(a, off);
      base  = a + off;
      avail = s - off;
      rem   = avail - need;
      if (rem <= OVERHEAD) begin
         grant = avail;
      end else begin
         grant = need;
         if (work_cnt >= DEPTH) begin
            res.status = ST_FULL;
            return res;
         end
         insert_hole(base + need, rem);
      end
      for (int j = 0; j < DEPTH; j++) begin
         hole_addr[j] = work_addr[j];
         hole_len[j]  = work_len[j];
      end
      hole_cnt    = work_cnt;
      heap_top    = top;
      res.address = base + HEADER_BYTES;
      res.granted = grant;
      res.status  = st;
      return res;
   endfunction

   // sender: hold one item until taken, then maybe leave a gap
   task automatic send_request(logic [23:0] size, bit pa);
      req_tvalid <= 1'b1;
      req_tdata  <= size;
      req_tuser  <= pa;
      do @(posedge clock); while (!req_tready);
      pending_allocs.push_back(allocate(size, pa));
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         int gap;
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // wait until every expected item has come and the block settles
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_allocs.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_register(logic [REG_INDEX_W-1:0] idx, logic [31:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_BODY_START: begin
            body_start_q = value;
            reload_holes();
         end
         REG_INITIAL_END: begin
            initial_end_q = value;
            reload_holes();
         end
         REG_MAX_END: max_end_q = value;
         default: ;
      endcase
   endtask

   task automatic load_heap(logic [31:0] body, logic [31:0] init_end, logic [31:0] top_limit);
      write_register(REG_BODY_START, body);
      write_register(REG_INITIAL_END, init_end);
      write_register(REG_MAX_END, top_limit);
   endtask

   function automatic logic [23:0] pick_size();
      int k;
      k = $urandom_range(0, 99);
      if (k < 60) return 24'($urandom_range(0, 300));
      if (k < 85) return 24'($urandom_range(0, 8191));
      if (k < 95) return 24'($urandom_range(0, 1 << 20));
      return 24'($urandom);
   endfunction

   // exact fit, growth, alignment and largest sizes
   task automatic test_basic_requests();
      load_heap(32'h0, RST_INITIAL_END, RST_MAX_END);
      send_request(24'(RST_INITIAL_END - OVERHEAD - 10), 1'b0);
      send_request(24'd0, 1'b0);
      send_request(24'd0, 1'b1);
      send_request(24'hFFFFFF, 1'b1);
      send_request(24'hFFFFFF, 1'b0);
      send_request(24'd100, 1'b1);
      send_request(24'd4076, 1'b1);
      send_request(24'd1, 1'b0);
      drain();
   endtask

   // register extremes, heap limit and ignored index
   task automatic test_register_extremes();
      write_register(REG_MAX_END, 32'h0);
      send_request(24'd5000, 1'b0);
      send_request(24'd0, 1'b1);
      drain();
      load_heap(32'hFFFFF000, 32'hFFFFF000, 32'hFFFFFFFF);
      send_request(24'd0, 1'b0);
      send_request(24'd10, 1'b1);
      drain();
      load_heap(32'h0, 32'h0, 32'hFFFFFFFF);
      write_register(REG_UNUSED, $urandom);
      send_request(24'd0, 1'b0);
      send_request(24'd0, 1'b1);
      send_request(24'hFFFFFF, 1'b1);
      drain();
      load_heap(32'h00010000, 32'h00008000, RST_MAX_END);
      send_request(24'd64, 1'b0);
      send_request(24'd64, 1'b1);
      drain();
   endtask

   // aligned requests add holes until the table is full
   task automatic test_table_full();
      load_heap(32'h1000, 32'h10000000, RST_MAX_END);
      repeat (75) send_request(24'($urandom_range(0, 100)), 1'b1);
      repeat (5) send_request(24'($urandom_range(0, 100)), 1'b0);
      send_request(24'hFFFFFF, 1'b0);
      drain();
   endtask

   // random requests over a series of random heaps
   task automatic test_random_requests();
      logic [31:0] body, init_end, limit;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 150 == 0) begin
            if (n != 0) drain();
            body     = {20'($urandom_range(0, 32'hFFFFF)), 12'h0};
            init_end = body + 32'($urandom_range(0, 256)) * PAGE;
            limit    = ($urandom_range(0, 2) == 0) ? init_end + 32'($urandom_range(0, 4096)) * PAGE
                                                   : RST_MAX_END;
            if ($urandom_range(0, 9) == 0) body = $urandom;
            load_heap(body, init_end, limit);
         end
         // hold off once until the block is empty
         if (n == RANDOM_ITEMS / 2) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (pending_allocs.size() != 0) @(posedge clock);
         end
         send_request(pick_size(), 1'($urandom));
      end
      drain();
   endtask

   // receiver backpressure pattern
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count % 300 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom);
         2: rsp_tready <= ($urandom_range(0, 3) == 0);
         default: rsp_tready <= (cycle_count % 16) >= 10;
      endcase
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_allocs.size() == 0) begin
            report_mismatch("unexpected item", rsp_tdata[31:0], 32'd0);
         end else begin
            alloc_result want;
            want = pending_allocs.pop_front();
            if (rsp_tdata[31:0] !== want.address)
               report_mismatch("block_address", rsp_tdata[31:0], want.address);
            if (rsp_tdata[63:32] !== want.granted)
               report_mismatch("granted_size", rsp_tdata[63:32], want.granted);
            if (rsp_tuser !== want.status)
               report_mismatch("status", 32'(rsp_tuser), 32'(want.status));
         end
      end
   end

   // watchdog on cycles with no handshake
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = '0;
      csr_we       = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      burst_left   = 0;
      body_start_q  = RST_BODY_START;
      initial_end_q = RST_INITIAL_END;
      max_end_q     = RST_MAX_END;
      reload_holes();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_basic_requests();
      test_register_extremes();
      test_table_full();
      test_random_requests();

      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
